[rtl/mtg_pkg.sv]
// Shared constants, widths and the tempering function of the keystream cipher.
package mtg_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TW_N   = 624;
  localparam int unsigned TW_M   = 397;
  localparam int unsigned IDX_W  = $clog2(TW_N);

  localparam logic [WORD_W-1:0] TW_MATRIX    = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TW_INIT_MULT = 32'd1812433253;
  localparam logic [WORD_W-1:0] KEY_RESET    = 32'd5489;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

  // Standard output tempering of a twisted word.
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w_in);
    logic [WORD_W-1:0] w;
    w = w_in;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & TEMPER_B);
    w = w ^ ((w << 15) & TEMPER_C);
    w = w ^ (w >> 18);
    return w;
  endfunction

endpackage

[rtl/mtg_if.sv]
// Valid/ready channel interfaces for input bytes and cipher bytes.
interface mtg_in_if;
  logic                        valid;
  logic                        ready;
  logic [mtg_pkg::BYTE_W-1:0]  data_byte;
  logic                        start_message;

  modport source (output valid, output data_byte, output start_message, input ready);
  modport sink   (input valid, input data_byte, input start_message, output ready);
endinterface

interface mtg_out_if;
  logic                        valid;
  logic                        ready;
  logic [mtg_pkg::BYTE_W-1:0]  cipher_byte;

  modport source (output valid, output cipher_byte, input ready);
  modport sink   (input valid, input cipher_byte, output ready);
endinterface

[rtl/mt19937_gamma_byte_cipher_top.sv]
// Top level of the byte-stream XOR cipher keyed by a Mersenne Twister.
//
// Usage:
//   in_ch  : byte requests (data_byte, start_message), valid/ready.
//   out_ch : cipher byte requests, valid/ready, one out for each one in.
//   cfg_we/cfg_wdata : write key_seed; write only while the block is idle.
// A request with start_message set, or the first request after reset,
// reseeds the 624-word table from key_seed before its byte is processed.
// Steps per request:
//   continuing byte : accepted while idle, then two memory read steps and one
//                     twist/write step that loads the result, or an emit step
//                     that waits for the output register; ready again in idle.
//   start byte      : a seed pass first writes word 0 from key_seed, then each
//                     further word in a multiply step and a write step, through the single shared multiplier.
// The table sits in a two-read, one-write memory with registered reads.
// Reset clears the sequencer, the read index and the seeded flag and sets
// key_seed to 5489; the table is left unwritten until the first seed pass.
// A receiver stall holds the result in the output register; the block still
// takes the next request and works on it, and waits only when it has a new
// result to hand over while the previous one is still held.
module mt19937_gamma_byte_cipher_top (
  input  logic                       clk,
  input  logic                       rst_n,
  mtg_in_if.sink                     in_ch,
  mtg_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [mtg_pkg::WORD_W-1:0] cfg_wdata
);
  import mtg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED0,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_RD_A,
    ST_RD_B,
    ST_TWIST,
    ST_EMIT
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TW_N - 1);
  localparam logic [IDX_W:0]   M_EXT    = (IDX_W+1)'(TW_M);
  localparam logic [IDX_W:0]   N_EXT    = (IDX_W+1)'(TW_N);

  state_t              state_r;
  logic [WORD_W-1:0]   key_r;
  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    cnt_r;
  logic                seeded_r;
  logic [BYTE_W-1:0]   data_r;
  logic [WORD_W-1:0]   prev_r;
  logic [WORD_W-1:0]   prod_r;
  logic [WORD_W-1:0]   y_r;
  logic [BYTE_W-1:0]   cipher_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                out_valid_r;

  // Table memory: one write port, two registered read ports.
  logic [WORD_W-1:0]   mem [0:TW_N-1];
  logic [WORD_W-1:0]   rd0_r;
  logic [WORD_W-1:0]   rd1_r;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;
  logic [IDX_W-1:0]    raddr0;
  logic [IDX_W-1:0]    raddr1;

  logic                in_acc;
  logic                need_seed;
  logic                out_free;
  logic                out_load;
  logic [IDX_W-1:0]    idx_p1;
  logic [IDX_W:0]      idx_sum;
  logic [IDX_W-1:0]    idx_m;
  logic [WORD_W-1:0]   mix;
  logic [WORD_W-1:0]   seed_word;
  logic [WORD_W-1:0]   twist_word;
  logic [WORD_W-1:0]   tempered_word;
  logic [BYTE_W-1:0]   ks_byte;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign in_acc             = in_ch.valid && in_ch.ready;
  assign need_seed          = in_ch.start_message || !seeded_r;
  assign out_free           = !out_valid_r || out_ch.ready;
  assign out_load           = out_free && (state_r == ST_TWIST || state_r == ST_EMIT);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.cipher_byte = out_byte_r;

  // Circular neighbours of the read index.
  assign idx_p1  = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
  assign idx_sum = {1'b0, idx_r} + M_EXT;
  assign idx_m   = (idx_sum >= N_EXT) ? IDX_W'(idx_sum - N_EXT) : idx_sum[IDX_W-1:0];

  // Shared seed multiplier input, and the incremental seed word.
  assign mix       = prev_r ^ (prev_r >> 30);
  assign seed_word = prod_r + {{(WORD_W-IDX_W){1'b0}}, cnt_r};

  // Twist of one word from the upper bit of entry i and the rest of entry i+1.
  assign twist_word    = rd0_r ^ (y_r >> 1) ^ (y_r[0] ? TW_MATRIX : '0);
  assign tempered_word = temper(twist_word);
  assign ks_byte       = tempered_word[WORD_W-1 -: BYTE_W];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = twist_word;
    case (state_r)
      ST_SEED0: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = key_r;
      end
      ST_SEED_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = seed_word;
      end
      ST_TWIST: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign raddr0 = (state_r == ST_RD_A) ? idx_r : idx_m;
  assign raddr1 = idx_p1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd0_r <= mem[raddr0];
    rd1_r <= mem[raddr1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= KEY_RESET;
    end else if (cfg_we) begin
      key_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a fresh result, or drop the held one once the receiver takes it.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            data_r  <= in_ch.data_byte;
            state_r <= need_seed ? ST_SEED0 : ST_RD_A;
          end
        end
        ST_SEED0: begin
          prev_r  <= key_r;
          cnt_r   <= IDX_W'(1);
          state_r <= ST_SEED_MUL;
        end
        ST_SEED_MUL: begin
          prod_r  <= TW_INIT_MULT * mix;
          state_r <= ST_SEED_WR;
        end
        ST_SEED_WR: begin
          prev_r <= seed_word;
          if (cnt_r == LAST_IDX) begin
            idx_r    <= '0;
            seeded_r <= 1'b1;
            state_r  <= ST_RD_A;
          end else begin
            cnt_r   <= cnt_r + IDX_W'(1);
            state_r <= ST_SEED_MUL;
          end
        end
        ST_RD_A: begin
          state_r <= ST_RD_B;
        end
        ST_RD_B: begin
          y_r     <= {rd0_r[WORD_W-1], rd1_r[WORD_W-2:0]};
          state_r <= ST_TWIST;
        end
        ST_TWIST: begin
          idx_r <= idx_p1;
          if (out_free) begin
            out_byte_r <= data_r ^ ks_byte;
            state_r    <= ST_IDLE;
          end else begin
            cipher_r <= data_r ^ ks_byte;
            state_r  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Hold the byte until the output register is free.
          if (out_free) begin
            out_byte_r <= cipher_r;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r < IDX_W'(TW_N))
    else $error("read index left the table");

  a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |=> seeded_r)
    else $error("seeded flag fell without reset");

  a_seed_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEED_WR && cnt_r == LAST_IDX) |=> (idx_r == '0 && state_r == ST_RD_A))
    else $error("seed pass did not restart the read index");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_TWIST || $past(state_r) == ST_EMIT))
    else $error("result appeared outside the twist step");

  a_unseeded_seeds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !seeded_r) |=> state_r == ST_SEED0)
    else $error("first byte processed without seeding");

endmodule
